### sv/ptd_pkg.sv
// Package for the periodic task dispatcher.
// Holds opcodes, result kinds, the controller state type and the command and status structs.
// Depends on nothing.
`timescale 1ns / 1ps
package ptd_pkg;

    localparam int unsigned DefSlotCount = 8;
    localparam int unsigned PeriodW      = 16;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_SUSPEND = 3'd2,
        OP_RESUME  = 3'd3,
        OP_DELETE  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        KIND_DUE    = 2'd0,
        KIND_IDLE   = 2'd1,
        KIND_OK     = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_TICK,
        ST_SLOT,
        ST_MOD,
        ST_EVAL,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec_cmd;
        logic tick_inc;
        logic mod_init;
        logic mod_step;
        logic slot_done;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic eligible;
        logic mod_done;
        logic slot_last;
    } t_status;

endpackage

### sv/periodic_task_dispatcher.sv
// Top level of the periodic task dispatcher.
// Depends on ptd_pkg, ptd_ctrl and ptd_dp.
`timescale 1ns / 1ps
// A word is taken when start is high and busy is low. A command's result is
// registered in the CMD state that follows the capture. A tick passes TICK, a
// SLOT state per slot and, per runnable slot, the 16-step serial remainder unit
// (MOD) and EVAL, then FINISH. Results appear for one cycle with o_strobe and
// cannot be stalled; they come in slot order, last one marked.
module periodic_task_dispatcher
    import ptd_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = DefSlotCount
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic [3:0]  i_task_id,
    input  logic [15:0] i_period,
    input  logic        i_handler_given,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_due_task,
    output logic [15:0] o_tick_now,
    output logic        o_last
);

    t_cmd    cmd;
    t_status status;

    ptd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    ptd_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_op            (i_op),
        .i_task_id       (i_task_id),
        .i_period        (i_period),
        .i_handler_given (i_handler_given),
        .o_strobe        (o_strobe),
        .o_kind          (o_kind),
        .o_due_task      (o_due_task),
        .o_tick_now      (o_tick_now),
        .o_last          (o_last)
    );

endmodule

### sv/ptd_ctrl.sv
// Controller state machine of the periodic task dispatcher.
// Depends on ptd_pkg.
`timescale 1ns / 1ps
module ptd_ctrl
    import ptd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_CMD;
                end
            end
            ST_CMD: begin
                if (i_status.is_tick) begin
                    n_state = ST_TICK;
                end else begin
                    o_cmd.exec_cmd = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_TICK: begin
                o_cmd.tick_inc = 1'b1;
                n_state = ST_SLOT;
            end
            ST_SLOT: begin
                if (i_status.eligible) begin
                    o_cmd.mod_init = 1'b1;
                    n_state = ST_MOD;
                end else begin
                    o_cmd.slot_done = 1'b1;
                    n_state = i_status.slot_last ? ST_FINISH : ST_SLOT;
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_done) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.slot_done = 1'b1;
                n_state = i_status.slot_last ? ST_FINISH : ST_SLOT;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/ptd_dp.sv
// Datapath of the periodic task dispatcher: slot table, tick count,
// bit-serial remainder unit and result register. Depends on ptd_pkg.
`timescale 1ns / 1ps
module ptd_dp
    import ptd_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = DefSlotCount
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_status       o_status,
    input  logic [2:0]    i_op,
    input  logic [3:0]    i_task_id,
    input  logic [15:0]   i_period,
    input  logic          i_handler_given,
    output logic          o_strobe,
    output logic [1:0]    o_kind,
    output logic [3:0]    o_due_task,
    output logic [15:0]   o_tick_now,
    output logic          o_last
);

    localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SW-1:0] LastSlot = SW'(SLOT_COUNT - 1);

    logic [SLOT_COUNT-1:0] r_present, r_resumed;
    logic [15:0]           r_period_tab [SLOT_COUNT];
    logic [15:0]           r_tick;

    logic [2:0]  r_op;
    logic [3:0]  r_id;
    logic [15:0] r_per;
    logic        r_hnd;

    logic [SW-1:0] r_slot;
    logic [15:0]   r_rem, r_dvd;
    logic [3:0]    r_bit;
    logic          r_pend;
    logic [SW-1:0] r_pend_slot;

    logic          id_ok;
    logic [SW-1:0] id_idx;
    logic          cmd_ok;
    logic [16:0]   rem_sh;
    logic [16:0]   rem_sub;

    assign id_ok  = ({28'd0, r_id} < 32'(SLOT_COUNT));
    assign id_idx = r_id[SW-1:0];

    // Command outcome.
    always_comb begin
        cmd_ok = 1'b0;
        if (id_ok) begin
            case (r_op)
                OP_CREATE:  cmd_ok = r_hnd && !r_present[id_idx];
                OP_SUSPEND, OP_RESUME, OP_DELETE: cmd_ok = 1'b1;
                default:    cmd_ok = 1'b0;
            endcase
        end
    end

    // One restoring step of tick modulo period.
    assign rem_sh  = {r_rem, r_dvd[15]};
    assign rem_sub = rem_sh - {1'b0, r_period_tab[r_slot]};

    assign o_status.is_tick   = (r_op == OP_TICK);
    assign o_status.eligible  = r_present[r_slot] && r_resumed[r_slot]
                                && (r_period_tab[r_slot] != 16'd0);
    assign o_status.mod_done  = (r_bit == 4'd15);
    assign o_status.slot_last = (r_slot == LastSlot);

    // Captured input word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_id  <= i_task_id;
            r_per <= i_period;
            r_hnd <= i_handler_given;
        end
    end

    // Slot table and tick count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_resumed <= '0;
            r_tick    <= '0;
            for (int i = 0; i < int'(SLOT_COUNT); i++) begin
                r_period_tab[i] <= '0;
            end
        end else begin
            if (i_cmd.tick_inc) begin
                r_tick <= r_tick + 16'd1;
            end
            if (i_cmd.exec_cmd && cmd_ok) begin
                case (r_op)
                    OP_CREATE: begin
                        r_present[id_idx]    <= 1'b1;
                        r_resumed[id_idx]    <= 1'b1;
                        r_period_tab[id_idx] <= r_per;
                    end
                    OP_SUSPEND: r_resumed[id_idx] <= 1'b0;
                    OP_RESUME:  r_resumed[id_idx] <= 1'b1;
                    OP_DELETE:  r_present[id_idx] <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // Slot scan and remainder unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_pend <= 1'b0;
        end else begin
            if (i_cmd.tick_inc) begin
                r_slot <= '0;
                r_pend <= 1'b0;
            end
            if (i_cmd.slot_done) begin
                r_slot <= r_slot + SW'(1);
                if (o_status.eligible && r_rem == 16'd0) begin
                    r_pend      <= 1'b1;
                    r_pend_slot <= r_slot;
                end
            end
        end
        if (i_cmd.mod_init) begin
            r_rem <= '0;
            r_dvd <= r_tick;
            r_bit <= '0;
        end
        if (i_cmd.mod_step) begin
            r_rem <= rem_sub[16] ? rem_sh[15:0] : rem_sub[15:0];
            r_dvd <= {r_dvd[14:0], 1'b0};
            r_bit <= r_bit + 4'd1;
        end
    end

    // Result register; a found slot is held back until the next one or the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cmd.exec_cmd) begin
                o_strobe   <= 1'b1;
                o_kind     <= cmd_ok ? KIND_OK : KIND_REJECT;
                o_due_task <= r_id;
                o_tick_now <= r_tick;
                o_last     <= 1'b1;
            end
            if (i_cmd.slot_done && o_status.eligible && r_rem == 16'd0 && r_pend) begin
                o_strobe   <= 1'b1;
                o_kind     <= KIND_DUE;
                o_due_task <= 4'(r_pend_slot);
                o_tick_now <= r_tick;
                o_last     <= 1'b0;
            end
            if (i_cmd.finish) begin
                o_strobe   <= 1'b1;
                o_kind     <= r_pend ? KIND_DUE : KIND_IDLE;
                o_due_task <= r_pend ? 4'(r_pend_slot) : 4'd0;
                o_tick_now <= r_tick;
                o_last     <= 1'b1;
            end
        end
    end

endmodule

### tb/periodic_task_dispatcher_tb.sv
// Self-checking testbench for the periodic task dispatcher.
// Depends on ptd_pkg and periodic_task_dispatcher; a scoreboard class predicts each result.
`timescale 1ns / 1ps
module periodic_task_dispatcher_tb;
    import ptd_pkg::*;

    localparam int unsigned Slots = DefSlotCount;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [15:0] tick;
        logic        last;
    } t_result;

    // Scoreboard: holds a shadow copy of the task table and the results still owed.
    class dispatch_scoreboard;
        logic [15:0] tick_count;
        logic        present [Slots];
        logic        resumed [Slots];
        logic [15:0] period  [Slots];
        t_result     owed [$];
        int          errors;

        function void clear();
            tick_count = '0;
            for (int s = 0; s < Slots; s++) begin
                present[s] = 1'b0;
                resumed[s] = 1'b0;
                period[s]  = '0;
            end
            owed.delete();
            errors = 0;
        endfunction

        // Works out the results that one accepted word causes.
        function void note_word(logic [2:0] op, logic [3:0] id, logic [15:0] per,
                                logic handler);
            t_result r;
            int      n;
            logic    ok;
            n  = 0;
            ok = 1'b0;
            if (op == OP_TICK) begin
                tick_count = tick_count + 16'd1;
                for (int s = 0; s < Slots; s++) begin
                    if (present[s] && resumed[s] && period[s] != 0
                        && (tick_count % period[s]) == 0) begin
                        r = '{KIND_DUE, 4'(s), tick_count, 1'b0};
                        owed.push_back(r);
                        n++;
                    end
                end
                if (n == 0) owed.push_back('{KIND_IDLE, 4'd0, tick_count, 1'b1});
                else owed[owed.size()-1].last = 1'b1;
                return;
            end
            if (id < Slots) begin
                case (op)
                    OP_CREATE: begin
                        if (handler && !present[id]) begin
                            present[id] = 1'b1;
                            resumed[id] = 1'b1;
                            period[id]  = per;
                            ok = 1'b1;
                        end
                    end
                    OP_SUSPEND: begin resumed[id] = 1'b0; ok = 1'b1; end
                    OP_RESUME:  begin resumed[id] = 1'b1; ok = 1'b1; end
                    OP_DELETE:  begin present[id] = 1'b0; ok = 1'b1; end
                    default: ok = 1'b0;
                endcase
            end
            owed.push_back('{ok ? KIND_OK : KIND_REJECT, id, tick_count, 1'b1});
        endfunction

        // Compares one strobed result with the oldest one owed.
        function void check_result(t_result got);
            t_result want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_op;
    logic [3:0]  i_task_id;
    logic [15:0] i_period;
    logic        i_handler_given;
    logic        o_strobe;
    logic [1:0]  o_kind;
    logic [3:0]  o_due_task;
    logic [15:0] o_tick_now;
    logic        o_last;

    dispatch_scoreboard board;

    periodic_task_dispatcher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_task_id(i_task_id), .i_period(i_period),
        .i_handler_given(i_handler_given), .o_strobe(o_strobe), .o_kind(o_kind),
        .o_due_task(o_due_task), .o_tick_now(o_tick_now), .o_last(o_last)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    initial begin
        board = new();
        board.clear();
    end

    // Results are sampled at the edge that ends their cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) board.check_result('{o_kind, o_due_task, o_tick_now, o_last});
    end

    // Drives one word and holds it until the block takes it.
    task automatic send_word(logic [2:0] op, logic [3:0] id, logic [15:0] per, logic hnd);
        start           <= 1'b1;
        i_op            <= op;
        i_task_id       <= id;
        i_period        <= per;
        i_handler_given <= hnd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_word(op, id, per, hnd);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Mostly small periods so that ticks find work; now and then an extreme one.
    task automatic random_word();
        logic [2:0]  op;
        logic [3:0]  id;
        logic [15:0] per;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = OP_TICK;
        else if (pick < 65) op = OP_CREATE;
        else if (pick < 75) op = OP_SUSPEND;
        else if (pick < 83) op = OP_RESUME;
        else if (pick < 95) op = OP_DELETE;
        else                op = 3'($urandom_range(5, 7));
        id = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                         : 4'($urandom_range(0, Slots - 1));
        pick = $urandom_range(0, 19);
        if (pick == 0)      per = 16'($urandom);
        else if (pick == 1) per = 16'd0;
        else                per = 16'($urandom_range(1, 6));
        send_word(op, id, per, $urandom_range(0, 7) != 0);
    endtask

    initial begin
        int words;
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_op            <= OP_TICK;
        i_task_id       <= '0;
        i_period        <= '0;
        i_handler_given <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: ticks with nothing due, creates, rejections, every command.
        send_word(OP_TICK, 4'd0, 16'd0, 1'b0);
        send_word(OP_CREATE, 4'd0, 16'd1, 1'b1);
        send_word(OP_CREATE, 4'd0, 16'd2, 1'b1);
        send_word(OP_CREATE, 4'd1, 16'd2, 1'b0);
        send_word(OP_CREATE, 4'd1, 16'd0, 1'b1);
        send_word(OP_CREATE, 4'd7, 16'hFFFF, 1'b1);
        send_word(OP_CREATE, 4'd15, 16'd1, 1'b1);
        send_word(OP_SUSPEND, 4'd8, 16'd0, 1'b0);
        send_word(3'd7, 4'd2, 16'd0, 1'b1);
        send_word(3'd5, 4'd2, 16'd0, 1'b1);
        for (int s = 2; s < 7; s++) send_word(OP_CREATE, 4'(s), 16'd1, 1'b1);
        send_word(OP_TICK, 4'd0, 16'd0, 1'b0);
        send_word(OP_SUSPEND, 4'd3, 16'd0, 1'b0);
        send_word(OP_TICK, 4'd0, 16'd0, 1'b0);
        send_word(OP_RESUME, 4'd3, 16'd0, 1'b0);
        send_word(OP_DELETE, 4'd2, 16'd0, 1'b0);
        send_word(OP_SUSPEND, 4'd2, 16'd0, 1'b0);
        send_word(OP_CREATE, 4'd2, 16'd1, 1'b1);
        send_word(OP_TICK, 4'd0, 16'd0, 1'b0);

        // Hold off until every owed result has arrived.
        start <= 1'b0;
        while (board.owed.size() != 0) @(posedge i_clk);

        // Random part in bursts with gaps after some of them.
        words = 0;
        while (words < 370) begin
            int burst;
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++) begin
                random_word();
                words++;
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 15));
        end
        start <= 1'b0;

        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: about 400 words, each at most a full tick over all slots, plus gaps.
    initial begin
        #1000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
sv/ptd_pkg.sv
sv/ptd_ctrl.sv
sv/ptd_dp.sv
sv/periodic_task_dispatcher.sv
tb/periodic_task_dispatcher_tb.sv
